/* sv/fsk_pkg.sv */
// ----------------------------------------------------------------------------
// fsk_pkg
// Shared widths, codes and interface types of the frame skewness block.
// ----------------------------------------------------------------------------
package fsk_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 16;
   localparam int MAX_OBS     = 1024;
   localparam int COUNT_BITS  = 11;
   localparam int SKEW_BITS   = 22;
   localparam int S1_BITS     = 26;
   localparam int S2_BITS     = 42;
   localparam int S3_BITS     = 58;
   localparam int A_BITS      = 80;
   localparam int B_BITS      = 54;
   localparam int Y_BITS      = 160;
   localparam int WIDE_BITS   = 212;
   localparam int MPL_BITS    = 80;
   localparam int BIT_BITS    = $clog2(SKEW_BITS);
   localparam int REQ_BITS    = 16;
   localparam int RSP_BITS    = 40;

   localparam logic [SKEW_BITS-1:0] CAP_POS = {1'b0, {(SKEW_BITS-1){1'b1}}};
   localparam logic [SKEW_BITS-1:0] CAP_NEG = {1'b1, {(SKEW_BITS-1){1'b0}}};

   typedef enum logic [4:0] {
      OP_NONE,
      OP_STEP,
      OP_M_S3N,
      OP_M_ACCN,
      OP_SAVE_A,
      OP_M_S1S2,
      OP_M_ACC3N,
      OP_SUB_A,
      OP_M_S1SQ,
      OP_SAVE_B,
      OP_M_S1B,
      OP_ADD2_A,
      OP_M_S2N,
      OP_SUBR_B,
      OP_ABS_A,
      OP_M_AA,
      OP_SAVE_X,
      OP_M_BB,
      OP_M_ACCB,
      OP_SAVE_Y,
      OP_M_CC,
      OP_M_YACC,
      OP_TRY,
      OP_SKIP,
      OP_M_RR,
      OP_ROUND,
      OP_EMIT,
      OP_EMIT_DEGEN
   } dp_op_type;

   typedef enum logic [5:0] {
      S_ACCUM,
      S_DRAIN,
      S_RUN,
      S_M1,
      S_M2,
      S_SAVE_A,
      S_M3,
      S_M4,
      S_SUB_A,
      S_M5,
      S_SAVE_B,
      S_M6,
      S_ADD_A,
      S_M7,
      S_SUBR_B,
      S_CHECK,
      S_ABS,
      S_M8,
      S_SAVE_X,
      S_M9,
      S_M10,
      S_SAVE_Y,
      S_TRIAL,
      S_MY,
      S_TRY,
      S_RND,
      S_MRY,
      S_ROUND,
      S_EMIT,
      S_DEGEN
   } ctl_state_type;

   typedef struct packed {
      dp_op_type op;
      logic      take;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic b_zero;
      logic cand_ok;
      logic r_lt_cap;
      logic bit_last;
      logic out_full;
   } dp_status_type;

endpackage

/* sv/fsk_ctrl.sv */
// ----------------------------------------------------------------------------
// fsk_ctrl
// Sequencer that steps the datapath through the end-of-frame computation.
// ----------------------------------------------------------------------------
module fsk_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  fsk_pkg::dp_status_type status,
   output fsk_pkg::dp_cmd_type    cmd
);
   import fsk_pkg::*;

   ctl_state_type state_ff, state_in;
   ctl_state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACCUM;
         ret_ff   <= S_ACCUM;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         S_ACCUM: begin
            if (req_tvalid && req_tlast) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN:  state_in = S_M1;
         S_RUN: begin
            if (!status.busy) begin
               state_in = ret_ff;
            end
         end
         S_M1:     begin state_in = S_RUN; ret_in = S_M2;     end
         S_M2:     begin state_in = S_RUN; ret_in = S_SAVE_A; end
         S_SAVE_A: state_in = S_M3;
         S_M3:     begin state_in = S_RUN; ret_in = S_M4;     end
         S_M4:     begin state_in = S_RUN; ret_in = S_SUB_A;  end
         S_SUB_A:  state_in = S_M5;
         S_M5:     begin state_in = S_RUN; ret_in = S_SAVE_B; end
         S_SAVE_B: state_in = S_M6;
         S_M6:     begin state_in = S_RUN; ret_in = S_ADD_A;  end
         S_ADD_A:  state_in = S_M7;
         S_M7:     begin state_in = S_RUN; ret_in = S_SUBR_B; end
         S_SUBR_B: state_in = S_CHECK;
         S_CHECK:  state_in = status.b_zero ? S_DEGEN : S_ABS;
         S_ABS:    state_in = S_M8;
         S_M8:     begin state_in = S_RUN; ret_in = S_SAVE_X; end
         S_SAVE_X: state_in = S_M9;
         S_M9:     begin state_in = S_RUN; ret_in = S_M10;    end
         S_M10:    begin state_in = S_RUN; ret_in = S_SAVE_Y; end
         S_SAVE_Y: state_in = S_TRIAL;
         S_TRIAL: begin
            if (status.cand_ok) begin
               state_in = S_RUN;
               ret_in   = S_MY;
            end else if (status.bit_last) begin
               state_in = S_RND;
            end
         end
         S_MY:     begin state_in = S_RUN; ret_in = S_TRY; end
         S_TRY:    state_in = status.bit_last ? S_RND : S_TRIAL;
         S_RND: begin
            if (status.r_lt_cap) begin
               state_in = S_RUN;
               ret_in   = S_MRY;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_MRY:    begin state_in = S_RUN; ret_in = S_ROUND; end
         S_ROUND:  state_in = S_EMIT;
         S_EMIT, S_DEGEN: begin
            if (!status.out_full) begin
               state_in = S_ACCUM;
            end
         end
         default:  state_in = S_ACCUM;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.op     = OP_NONE;
      cmd.take   = 1'b0;
      case (state_ff)
         S_ACCUM: begin
            req_tready = 1'b1;
            cmd.take   = req_tvalid;
         end
         S_RUN:    cmd.op = status.busy ? OP_STEP : OP_NONE;
         S_M1:     cmd.op = OP_M_S3N;
         S_M2:     cmd.op = OP_M_ACCN;
         S_SAVE_A: cmd.op = OP_SAVE_A;
         S_M3:     cmd.op = OP_M_S1S2;
         S_M4:     cmd.op = OP_M_ACC3N;
         S_SUB_A:  cmd.op = OP_SUB_A;
         S_M5:     cmd.op = OP_M_S1SQ;
         S_SAVE_B: cmd.op = OP_SAVE_B;
         S_M6:     cmd.op = OP_M_S1B;
         S_ADD_A:  cmd.op = OP_ADD2_A;
         S_M7:     cmd.op = OP_M_S2N;
         S_SUBR_B: cmd.op = OP_SUBR_B;
         S_ABS:    cmd.op = OP_ABS_A;
         S_M8:     cmd.op = OP_M_AA;
         S_SAVE_X: cmd.op = OP_SAVE_X;
         S_M9:     cmd.op = OP_M_BB;
         S_M10:    cmd.op = OP_M_ACCB;
         S_SAVE_Y: cmd.op = OP_SAVE_Y;
         S_TRIAL:  cmd.op = status.cand_ok ? OP_M_CC : OP_SKIP;
         S_MY:     cmd.op = OP_M_YACC;
         S_TRY:    cmd.op = OP_TRY;
         S_RND:    cmd.op = status.r_lt_cap ? OP_M_RR : OP_NONE;
         S_MRY:    cmd.op = OP_M_YACC;
         S_ROUND:  cmd.op = OP_ROUND;
         S_EMIT:   cmd.op = status.out_full ? OP_NONE : OP_EMIT;
         S_DEGEN:  cmd.op = status.out_full ? OP_NONE : OP_EMIT_DEGEN;
         default:  cmd.op = OP_NONE;
      endcase
   end

endmodule

/* sv/fsk_datapath.sv */
// ----------------------------------------------------------------------------
// fsk_datapath
// Running sums, shared shift-add multiplier, bitwise root search and the
// output register.
// ----------------------------------------------------------------------------
module fsk_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fsk_pkg::dp_cmd_type                   cmd,
   output fsk_pkg::dp_status_type                status,
   input  logic signed [fsk_pkg::SAMPLE_BITS-1:0] sample,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic        [fsk_pkg::SKEW_BITS-1:0]  skewness,
   output logic                                  degenerate,
   output logic        [fsk_pkg::COUNT_BITS-1:0] observation_count
);
   import fsk_pkg::*;

   logic        [COUNT_BITS-1:0]  n_ff, n_in;
   logic signed [S1_BITS-1:0]     s1_ff, s1_in;
   logic        [S2_BITS-1:0]     s2_ff, s2_in;
   logic signed [S3_BITS-1:0]     s3_ff, s3_in;
   logic                          va_ff, va_in;
   logic signed [SAMPLE_BITS-1:0] xa_ff, xa_in;
   logic signed [2*SAMPLE_BITS-1:0] sqa_ff, sqa_in;

   logic signed [WIDE_BITS-1:0]   acc_ff, acc_in;
   logic signed [WIDE_BITS-1:0]   mcand_ff, mcand_in;
   logic        [MPL_BITS-1:0]    mplier_ff, mplier_in;
   logic signed [A_BITS-1:0]      a_ff, a_in;
   logic        [B_BITS-1:0]      b_ff, b_in;
   logic        [WIDE_BITS-1:0]   x_ff, x_in;
   logic        [Y_BITS-1:0]      y_ff, y_in;
   logic        [SKEW_BITS-1:0]   r_ff, r_in;
   logic        [BIT_BITS-1:0]    bit_ff, bit_in;
   logic                          neg_ff, neg_in;

   logic                          vld_ff, vld_in;
   logic        [SKEW_BITS-1:0]   skew_ff, skew_in;
   logic                          degen_ff, degen_in;
   logic        [COUNT_BITS-1:0]  cnt_ff, cnt_in;

   logic signed [2*SAMPLE_BITS-1:0] sq_w;
   logic signed [3*SAMPLE_BITS-1:0] cube_w;
   logic        [S1_BITS-1:0]     s1_abs;
   logic        [SKEW_BITS-1:0]   cand;
   logic        [SKEW_BITS-1:0]   cap;
   logic        [SKEW_BITS:0]     rr;
   logic        [COUNT_BITS+1:0]  n3;
   logic        [WIDE_BITS-1:0]   acc_u;

   assign sq_w   = (2*SAMPLE_BITS)'(sample) * (2*SAMPLE_BITS)'(sample);
   assign cube_w = (3*SAMPLE_BITS)'(sqa_ff) * (3*SAMPLE_BITS)'(xa_ff);
   assign s1_abs = s1_ff[S1_BITS-1] ? (S1_BITS'(0) - s1_ff) : s1_ff;
   assign cand   = r_ff | (SKEW_BITS'(1) << bit_ff);
   assign cap    = neg_ff ? CAP_NEG : CAP_POS;
   assign rr     = {r_ff, 1'b1};
   assign n3     = (COUNT_BITS+2)'(n_ff) + ((COUNT_BITS+2)'(n_ff) << 1);
   assign acc_u  = acc_ff;

   assign status.busy     = (mplier_ff != '0);
   assign status.b_zero   = (b_ff == '0);
   assign status.cand_ok  = (cand <= cap);
   assign status.r_lt_cap = (r_ff < cap);
   assign status.bit_last = (bit_ff == '0);
   assign status.out_full = vld_ff;

   assign rsp_tvalid        = vld_ff;
   assign skewness          = skew_ff;
   assign degenerate        = degen_ff;
   assign observation_count = cnt_ff;

   always_comb begin
      n_in      = n_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      s3_in     = s3_ff;
      va_in     = 1'b0;
      xa_in     = xa_ff;
      sqa_in    = sqa_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      r_in      = r_ff;
      bit_in    = bit_ff;
      neg_in    = neg_ff;
      vld_in    = vld_ff && !rsp_tready;
      skew_in   = skew_ff;
      degen_in  = degen_ff;
      cnt_in    = cnt_ff;

      if (cmd.take && (n_ff < COUNT_BITS'(MAX_OBS))) begin
         n_in   = n_ff + 1'b1;
         va_in  = 1'b1;
         xa_in  = sample;
         sqa_in = sq_w;
      end
      if (va_ff) begin
         s1_in = s1_ff + S1_BITS'(xa_ff);
         s2_in = s2_ff + S2_BITS'($unsigned(sqa_ff));
         s3_in = s3_ff + S3_BITS'(cube_w);
      end

      case (cmd.op)
         OP_STEP: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
         end
         OP_M_S3N: begin
            acc_in = '0; mcand_in = WIDE_BITS'(s3_ff); mplier_in = MPL_BITS'(n_ff);
         end
         OP_M_ACCN: begin
            acc_in = '0; mcand_in = acc_ff; mplier_in = MPL_BITS'(n_ff);
         end
         OP_SAVE_A:  a_in = A_BITS'(acc_ff);
         OP_M_S1S2: begin
            acc_in = '0; mcand_in = WIDE_BITS'(s1_ff); mplier_in = MPL_BITS'(s2_ff);
         end
         OP_M_ACC3N: begin
            acc_in = '0; mcand_in = acc_ff; mplier_in = MPL_BITS'(n3);
         end
         OP_SUB_A:   a_in = a_ff - A_BITS'(acc_ff);
         OP_M_S1SQ: begin
            acc_in = '0; mcand_in = WIDE_BITS'(s1_abs); mplier_in = MPL_BITS'(s1_abs);
         end
         OP_SAVE_B:  b_in = B_BITS'(acc_ff);
         OP_M_S1B: begin
            acc_in = '0; mcand_in = WIDE_BITS'(s1_ff); mplier_in = MPL_BITS'(b_ff);
         end
         OP_ADD2_A:  a_in = a_ff + (A_BITS'(acc_ff) <<< 1);
         OP_M_S2N: begin
            acc_in = '0; mcand_in = WIDE_BITS'(s2_ff); mplier_in = MPL_BITS'(n_ff);
         end
         OP_SUBR_B:  b_in = B_BITS'(acc_ff) - b_ff;
         OP_ABS_A: begin
            neg_in = a_ff[A_BITS-1];
            a_in   = a_ff[A_BITS-1] ? (A_BITS'(0) - a_ff) : a_ff;
            r_in   = '0;
            bit_in = BIT_BITS'(SKEW_BITS - 1);
         end
         OP_M_AA: begin
            acc_in = '0; mcand_in = WIDE_BITS'(a_ff); mplier_in = MPL_BITS'($unsigned(a_ff));
         end
         OP_SAVE_X:  x_in = acc_u << (2*FRAC_BITS);
         OP_M_BB: begin
            acc_in = '0; mcand_in = WIDE_BITS'(b_ff); mplier_in = MPL_BITS'(b_ff);
         end
         OP_M_ACCB: begin
            acc_in = '0; mcand_in = acc_ff; mplier_in = MPL_BITS'(b_ff);
         end
         OP_SAVE_Y:  y_in = Y_BITS'(acc_u);
         OP_M_CC: begin
            acc_in = '0; mcand_in = WIDE_BITS'(cand); mplier_in = MPL_BITS'(cand);
         end
         OP_M_YACC: begin
            acc_in = '0; mcand_in = WIDE_BITS'(y_ff); mplier_in = acc_u[MPL_BITS-1:0];
         end
         OP_TRY: begin
            if (acc_u <= x_ff) begin
               r_in = cand;
            end
            bit_in = bit_ff - 1'b1;
         end
         OP_SKIP:    bit_in = bit_ff - 1'b1;
         OP_M_RR: begin
            acc_in = '0; mcand_in = WIDE_BITS'(rr); mplier_in = MPL_BITS'(rr);
         end
         OP_ROUND: begin
            if (acc_u <= (x_ff << 2)) begin
               r_in = r_ff + 1'b1;
            end
         end
         OP_EMIT, OP_EMIT_DEGEN: begin
            vld_in   = 1'b1;
            cnt_in   = n_ff;
            degen_in = (cmd.op == OP_EMIT_DEGEN);
            skew_in  = (cmd.op == OP_EMIT_DEGEN) ? '0 :
                       (neg_ff ? (SKEW_BITS'(0) - r_ff) : r_ff);
            n_in     = '0;
            s1_in    = '0;
            s2_in    = '0;
            s3_in    = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= '0;
         s1_ff  <= '0;
         s2_ff  <= '0;
         s3_ff  <= '0;
         va_ff  <= 1'b0;
         vld_ff <= 1'b0;
         mplier_ff <= '0;
      end else begin
         n_ff   <= n_in;
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         va_ff  <= va_in;
         vld_ff <= vld_in;
         mplier_ff <= mplier_in;
      end
   end

   always_ff @(posedge clock) begin
      xa_ff    <= xa_in;
      sqa_ff   <= sqa_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      r_ff     <= r_in;
      bit_ff   <= bit_in;
      neg_ff   <= neg_in;
      skew_ff  <= skew_in;
      degen_ff <= degen_in;
      cnt_ff   <= cnt_in;
   end

endmodule

/* sv/frame_skewness.sv */
// ----------------------------------------------------------------------------
// frame_skewness
// Skewness of a frame of signed samples, with 16 fraction bits, saturated.
// ----------------------------------------------------------------------------
// Throughput: one sample word per cycle while a frame streams in.
// After the last word the result is computed with the shared 1-bit-per-cycle
// shift-add multiplier and the 22-step root search, then registered; no word is
// taken from the last word until the result is loaded.
// Reset clears the sums, the count and the control; no clearing pass is needed.
module frame_skewness (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fsk_pkg::REQ_BITS-1:0]     req_tdata,  // sample
   input  logic                             req_tlast,  // last_of_frame
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fsk_pkg::RSP_BITS-1:0]     rsp_tdata,  // skewness, observation_count
   output logic                             rsp_tuser   // degenerate
);
   import fsk_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [SKEW_BITS-1:0]  skewness;
   logic [COUNT_BITS-1:0] observation_count;

   fsk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fsk_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .sample            ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .skewness          (skewness),
      .degenerate        (rsp_tuser),
      .observation_count (observation_count)
   );

   assign rsp_tdata = {(RSP_BITS - SKEW_BITS - COUNT_BITS)'(0), observation_count, skewness};

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> skewness == '0)
      else $error("degenerate result with nonzero skewness");

   a_count_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> observation_count != '0)
      else $error("result with zero observations");

   a_last_stalls : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after the last word of a frame");

endmodule
